[hw/rtl/dfr_pkg.sv]
// types, codes and constants shared by the debug frame receiver files
package dfr_pkg;

    localparam logic [7:0] REG_RESET_VALUE = 8'hF0;

    // register index codes, byte address bit 2 selects
    typedef enum logic {
        REG_MIN_FUNC = 1'b0,
        REG_MAX_LEN  = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        PH_FUNC = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_BAD     = 3'd3,
        KIND_ABORT   = 3'd4
    } t_kind;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } t_operation;

    typedef struct packed {
        t_operation operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] function_code;
        logic [7:0] frame_length;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
    } t_out_item;

endpackage

[hw/rtl/debug_frame_receiver.sv]
// debug monitor command frame receiver: byte-serial frame parser with checksum check
//
//  channel   direction  handshake                          payload
//  in        input      i_in_valid / o_in_stall            i_in_item  (dfr_pkg::t_in_item)
//  out       output     o_out_valid / i_out_stall          o_out_item (dfr_pkg::t_out_item)
//  config    input      psel / penable / pwrite / pready   paddr, pwdata, prdata
//
//  one transaction per cycle sustained while the output does not stall; items go from
//  input register to result register, with the frame parse done in one pass between them
//  reset (synchronous, active low) empties both registers and sends the parser to
//  waiting for a function code; both config registers come up at 0xF0
//  a stall on the output holds the result; the input stalls only when its register
//  is full and the result register cannot drain
module debug_frame_receiver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  dfr_pkg::t_in_item    i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output dfr_pkg::t_out_item   o_out_item,
    input  logic                 i_out_stall,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [7:0]          r_min_func;
    logic [7:0]          r_max_len;

    logic                r_in_valid;
    dfr_pkg::t_in_item   r_in;
    logic                r_out_valid;
    dfr_pkg::t_out_item  r_out;

    dfr_pkg::t_phase     r_phase,     n_phase;
    logic [7:0]          r_remaining, n_remaining;
    logic [7:0]          r_sum,       n_sum;
    logic [7:0]          r_func,      n_func;
    logic [7:0]          r_len,       n_len;
    logic [7:0]          r_pos,       n_pos;

    logic                advance;
    logic                in_fire;
    logic                produce;
    dfr_pkg::t_out_item  result;
    logic [7:0]          total;
    logic                cfg_write;
    dfr_pkg::t_reg_index cfg_sel;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = dfr_pkg::t_reg_index'(paddr[2]);

    always_comb begin
        case (cfg_sel)
            dfr_pkg::REG_MIN_FUNC: prdata = {24'd0, r_min_func};
            dfr_pkg::REG_MAX_LEN:  prdata = {24'd0, r_max_len};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_func <= dfr_pkg::REG_RESET_VALUE;
            r_max_len  <= dfr_pkg::REG_RESET_VALUE;
        end else if (cfg_write) begin
            if (cfg_sel == dfr_pkg::REG_MIN_FUNC) begin
                r_min_func <= pwdata[7:0];
            end else begin
                r_max_len <= pwdata[7:0];
            end
        end
    end

    // handshakes
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign total       = r_sum + r_in.rx_byte;

    // frame parse for the item in the input register
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_sum       = r_sum;
        n_func      = r_func;
        n_len       = r_len;
        n_pos       = r_pos;
        produce     = 1'b0;
        result.kind          = dfr_pkg::KIND_HEADER;
        result.function_code = r_func;
        result.frame_length  = r_len;
        result.payload_byte  = 8'd0;
        result.payload_index = 8'd0;

        if (r_in.operation == dfr_pkg::OP_TIMEOUT) begin
            if (r_phase == dfr_pkg::PH_DATA || r_phase == dfr_pkg::PH_SUM) begin
                produce     = 1'b1;
                result.kind = dfr_pkg::KIND_ABORT;
            end
            n_phase = dfr_pkg::PH_FUNC;
        end else begin
            case (r_phase)
                dfr_pkg::PH_FUNC: begin
                    if (r_in.rx_byte >= r_min_func) begin
                        n_func  = r_in.rx_byte;
                        n_sum   = r_in.rx_byte;
                        n_phase = dfr_pkg::PH_LEN;
                    end
                end
                dfr_pkg::PH_LEN: begin
                    if (r_in.rx_byte > r_max_len) begin
                        n_phase = dfr_pkg::PH_FUNC;
                    end else begin
                        n_len               = r_in.rx_byte;
                        n_remaining         = r_in.rx_byte;
                        n_pos               = 8'd0;
                        n_sum               = total;
                        n_phase             = (r_in.rx_byte == 8'd0) ? dfr_pkg::PH_SUM
                                                                     : dfr_pkg::PH_DATA;
                        produce             = 1'b1;
                        result.kind         = dfr_pkg::KIND_HEADER;
                        result.frame_length = r_in.rx_byte;
                    end
                end
                dfr_pkg::PH_DATA: begin
                    produce              = 1'b1;
                    result.kind          = dfr_pkg::KIND_PAYLOAD;
                    result.payload_byte  = r_in.rx_byte;
                    result.payload_index = r_pos;
                    n_sum                = total;
                    n_pos                = r_pos + 8'd1;
                    n_remaining          = r_remaining - 8'd1;
                    if (n_remaining == 8'd0) begin
                        n_phase = dfr_pkg::PH_SUM;
                    end
                end
                default: begin
                    produce     = 1'b1;
                    result.kind = (total == 8'd0) ? dfr_pkg::KIND_GOOD : dfr_pkg::KIND_BAD;
                    n_phase     = dfr_pkg::PH_FUNC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dfr_pkg::PH_FUNC;
            r_remaining <= 8'd0;
            r_sum       <= 8'd0;
            r_func      <= 8'd0;
            r_len       <= 8'd0;
            r_pos       <= 8'd0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
            r_func      <= n_func;
            r_len       <= n_len;
            r_pos       <= n_pos;
        end
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= produce;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_item;
        end
        if (advance && produce) begin
            r_out <= result;
        end
    end

endmodule

[hw/rtl/dfr_checker.sv]
// port-level checker for the debug frame receiver and its bind
module dfr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input dfr_pkg::t_out_item  o_out_item,
    input logic                i_out_stall,
    input logic                pready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    // data fields are zero outside payload results
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != dfr_pkg::KIND_PAYLOAD |->
            o_out_item.payload_byte == 8'd0 && o_out_item.payload_index == 8'd0)
        else $error("payload fields set outside a payload result");

    // the input only backs up when the output side does
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled with output free");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind debug_frame_receiver dfr_checker u_dfr_checker (.*);

[tb/sv/tb_top.sv]
// testbench for debug_frame_receiver: random framed bytes checked against a frame parser
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    dfr_pkg::t_in_item   i_in_item;
    logic                o_in_stall;
    logic                o_out_valid;
    dfr_pkg::t_out_item  o_out_item;
    logic                i_out_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    debug_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // serial events waiting to be driven, and results the parser predicts
    dfr_pkg::t_in_item  pending_events[$];
    dfr_pkg::t_out_item expected_results[$];

    int fail_count = 0;
    int cycle_count = 0;
    int queued_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit in_taken = 1'b0;

    // predicted configuration and parser state
    logic [7:0]       cfg_min_func = dfr_pkg::REG_RESET_VALUE;
    logic [7:0]       cfg_max_len = dfr_pkg::REG_RESET_VALUE;
    dfr_pkg::t_phase  parse_phase = dfr_pkg::PH_FUNC;
    logic [7:0]       bytes_left = '0;
    logic [7:0]       frame_sum = '0;
    logic [7:0]       held_func = '0;
    logic [7:0]       held_len = '0;
    logic [7:0]       next_index = '0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = ~i_clk;
    end

    function automatic void parse_frame_event(input dfr_pkg::t_in_item ev);
        dfr_pkg::t_out_item res;
        logic [7:0] total;
        res = '0;
        if (ev.operation == dfr_pkg::OP_TIMEOUT) begin
            if (parse_phase == dfr_pkg::PH_DATA || parse_phase == dfr_pkg::PH_SUM) begin
                res.kind = dfr_pkg::KIND_ABORT;
                res.function_code = held_func;
                res.frame_length = held_len;
                expected_results.push_back(res);
            end
            parse_phase = dfr_pkg::PH_FUNC;
            return;
        end
        case (parse_phase)
            dfr_pkg::PH_FUNC: begin
                if (ev.rx_byte >= cfg_min_func) begin
                    held_func = ev.rx_byte;
                    frame_sum = ev.rx_byte;
                    parse_phase = dfr_pkg::PH_LEN;
                end
            end
            dfr_pkg::PH_LEN: begin
                if (ev.rx_byte > cfg_max_len) begin
                    parse_phase = dfr_pkg::PH_FUNC;
                end else begin
                    held_len = ev.rx_byte;
                    bytes_left = ev.rx_byte;
                    next_index = '0;
                    frame_sum = frame_sum + ev.rx_byte;
                    parse_phase = (ev.rx_byte == 8'd0) ? dfr_pkg::PH_SUM : dfr_pkg::PH_DATA;
                    res.kind = dfr_pkg::KIND_HEADER;
                    res.function_code = held_func;
                    res.frame_length = held_len;
                    expected_results.push_back(res);
                end
            end
            dfr_pkg::PH_DATA: begin
                res.kind = dfr_pkg::KIND_PAYLOAD;
                res.function_code = held_func;
                res.frame_length = held_len;
                res.payload_byte = ev.rx_byte;
                res.payload_index = next_index;
                expected_results.push_back(res);
                frame_sum = frame_sum + ev.rx_byte;
                next_index = next_index + 8'd1;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    parse_phase = dfr_pkg::PH_SUM;
                end
            end
            default: begin
                total = frame_sum + ev.rx_byte;
                res.kind = (total == 8'd0) ? dfr_pkg::KIND_GOOD : dfr_pkg::KIND_BAD;
                res.function_code = held_func;
                res.frame_length = held_len;
                expected_results.push_back(res);
                parse_phase = dfr_pkg::PH_FUNC;
            end
        endcase
    endfunction

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // result monitor and prediction at the rising edge
    always @(posedge i_clk) begin : watch_results
        dfr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: kind %0d", o_out_item.kind);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", 8'(want.kind), 8'(o_out_item.kind));
                compare_field("function_code", want.function_code, o_out_item.function_code);
                compare_field("frame_length", want.frame_length, o_out_item.frame_length);
                compare_field("payload_byte", want.payload_byte, o_out_item.payload_byte);
                compare_field("payload_index", want.payload_index, o_out_item.payload_index);
            end
        end
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            parse_frame_event(i_in_item);
        end
    end

    // input driver and output stall, both at the falling edge
    always @(negedge i_clk) begin : drive_events
        dfr_pkg::t_in_item next_event;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_events.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_event = pending_events.pop_front();
                i_in_item <= next_event;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input dfr_pkg::t_reg_index idx, input logic [7:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            dfr_pkg::REG_MIN_FUNC: cfg_min_func = value;
            dfr_pkg::REG_MAX_LEN:  cfg_max_len = value;
            default:               cfg_max_len = cfg_max_len;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_event(input dfr_pkg::t_operation op, input logic [7:0] value);
        dfr_pkg::t_in_item ev;
        ev.operation = op;
        ev.rx_byte = value;
        pending_events.push_back(ev);
        queued_count++;
    endtask

    // whole frame with random payload; optionally a wrong checksum or cut short by a timeout
    task automatic queue_frame(input logic [7:0] func, input logic [7:0] len,
                               input bit corrupt, input bit truncate);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        logic [7:0] data;
        int i;
        int cut;
        frame_bytes.push_back(func);
        frame_bytes.push_back(len);
        sum = func + len;
        for (i = 0; i < int'(len); i++) begin
            data = 8'($urandom_range(255));
            frame_bytes.push_back(data);
            sum = sum + data;
        end
        data = 8'd0 - sum;
        if (corrupt) begin
            data = data + 8'($urandom_range(255, 1));
        end
        frame_bytes.push_back(data);
        cut = truncate ? int'($urandom_range(frame_bytes.size() - 1, 1)) : frame_bytes.size();
        for (i = 0; i < cut; i++) begin
            push_event(dfr_pkg::OP_BYTE, frame_bytes[i]);
        end
        if (truncate) begin
            push_event(dfr_pkg::OP_TIMEOUT, 8'($urandom_range(255)));
        end
    endtask

    task automatic queue_random_traffic(input int count);
        int target;
        int roll;
        logic [7:0] len_cap;
        logic [7:0] len;
        logic [7:0] func;
        target = queued_count + count;
        while (queued_count < target) begin
            roll = $urandom_range(99);
            len_cap = (cfg_max_len < 8'd8) ? cfg_max_len : 8'd8;
            if ($urandom_range(39) == 0) begin
                len = 8'($urandom_range(cfg_max_len, 0));
            end else begin
                len = 8'($urandom_range(len_cap, 0));
            end
            func = 8'($urandom_range(255, cfg_min_func));
            if (roll < 70) begin
                queue_frame(func, len, $urandom_range(99) < 15, 1'b0);
            end else if (roll < 80) begin
                queue_frame(func, len, 1'b0, 1'b1);
            end else if (roll < 86) begin
                push_event(dfr_pkg::OP_TIMEOUT, 8'($urandom_range(255)));
            end else if (roll < 91 && cfg_min_func > 8'd0) begin
                push_event(dfr_pkg::OP_BYTE, 8'($urandom_range(int'(cfg_min_func) - 1, 0)));
            end else if (roll < 96 && cfg_max_len < 8'd255) begin
                push_event(dfr_pkg::OP_BYTE, func);
                push_event(dfr_pkg::OP_BYTE, 8'($urandom_range(255, int'(cfg_max_len) + 1)));
            end else begin
                // stray byte, flushed by a timeout
                push_event(dfr_pkg::OP_BYTE, 8'($urandom_range(255)));
                push_event(dfr_pkg::OP_TIMEOUT, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained;
        while (pending_events.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration, no idling
        push_event(dfr_pkg::OP_TIMEOUT, 8'hFF);
        push_event(dfr_pkg::OP_BYTE, 8'h00);
        push_event(dfr_pkg::OP_BYTE, 8'hEF);
        push_event(dfr_pkg::OP_BYTE, 8'hF0);
        push_event(dfr_pkg::OP_BYTE, 8'h00);
        push_event(dfr_pkg::OP_BYTE, 8'h10);
        push_event(dfr_pkg::OP_BYTE, 8'hFF);
        push_event(dfr_pkg::OP_BYTE, 8'h02);
        push_event(dfr_pkg::OP_BYTE, 8'h00);
        push_event(dfr_pkg::OP_BYTE, 8'hFF);
        push_event(dfr_pkg::OP_BYTE, 8'h00);
        // length over the limit, then a fresh frame
        push_event(dfr_pkg::OP_BYTE, 8'hF5);
        push_event(dfr_pkg::OP_BYTE, 8'hF1);
        push_event(dfr_pkg::OP_BYTE, 8'hF0);
        push_event(dfr_pkg::OP_TIMEOUT, 8'h00);
        push_event(dfr_pkg::OP_BYTE, 8'hF0);
        push_event(dfr_pkg::OP_BYTE, 8'h01);
        push_event(dfr_pkg::OP_BYTE, 8'hAA);
        push_event(dfr_pkg::OP_BYTE, 8'h55);
        push_event(dfr_pkg::OP_BYTE, 8'hF0);
        push_event(dfr_pkg::OP_BYTE, 8'h03);
        push_event(dfr_pkg::OP_BYTE, 8'h11);
        push_event(dfr_pkg::OP_TIMEOUT, 8'h5A);
        push_event(dfr_pkg::OP_BYTE, 8'hF0);
        push_event(dfr_pkg::OP_BYTE, 8'h00);
        push_event(dfr_pkg::OP_TIMEOUT, 8'hA5);
        // sender holds off until everything has come back
        wait_drained();
        queue_random_traffic(320);
        wait_drained();

        // widest settings, sender mostly idle
        write_reg(dfr_pkg::REG_MIN_FUNC, 8'h00);
        write_reg(dfr_pkg::REG_MAX_LEN, 8'hFF);
        sender_idle_pct = 86;
        receiver_stall_pct = 0;
        queue_frame(8'h00, 8'hFF, 1'b0, 1'b0);
        queue_random_traffic(340);
        wait_drained();

        // narrowest settings, receiver mostly stalled
        write_reg(dfr_pkg::REG_MIN_FUNC, 8'hFF);
        write_reg(dfr_pkg::REG_MAX_LEN, 8'h00);
        sender_idle_pct = 0;
        receiver_stall_pct = 86;
        queue_random_traffic(340);
        wait_drained();

        // random settings, both sides idling
        write_reg(dfr_pkg::REG_MIN_FUNC, 8'($urandom_range(250, 0)));
        write_reg(dfr_pkg::REG_MAX_LEN, 8'($urandom_range(255, 0)));
        sender_idle_pct = 22;
        receiver_stall_pct = 22;
        queue_random_traffic(340);
        wait_drained();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dfr_pkg.sv
hw/rtl/debug_frame_receiver.sv
hw/rtl/dfr_checker.sv
tb/sv/tb_top.sv
